[hdl/psp_pkg.sv]
// types, constants and character classes shared by the format specifier parser
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

   localparam logic [31:0] SAT_MAX      = 32'h7FFF_FFFF;
   localparam logic [31:0] PREC_UNSET   = 32'hFFFF_FFFF;
   localparam logic [7:0]  SPAN_MAX     = 8'hFF;

   localparam logic [7:0]  CH_NUL       = 8'h00;
   localparam logic [7:0]  CH_MINUS     = 8'h2D;
   localparam logic [7:0]  CH_PLUS      = 8'h2B;
   localparam logic [7:0]  CH_SPACE     = 8'h20;
   localparam logic [7:0]  CH_HASH      = 8'h23;
   localparam logic [7:0]  CH_ZERO      = 8'h30;
   localparam logic [7:0]  CH_NINE      = 8'h39;
   localparam logic [7:0]  CH_DOT       = 8'h2E;
   localparam logic [7:0]  CH_STAR      = 8'h2A;
   localparam logic [7:0]  CH_LEN_H     = 8'h68;
   localparam logic [7:0]  CH_LEN_L     = 8'h6C;
   localparam logic [7:0]  CH_LEN_BIG_L = 8'h4C;

   localparam logic [1:0]  JUST_RIGHT   = 2'd0;
   localparam logic [1:0]  JUST_ZERO    = 2'd1;
   localparam logic [1:0]  JUST_LEFT    = 2'd2;

   localparam logic [1:0]  SIGN_NONE    = 2'd0;
   localparam logic [1:0]  SIGN_SPACE   = 2'd1;
   localparam logic [1:0]  SIGN_PLUS    = 2'd2;

   localparam logic [1:0]  LEN_NONE     = 2'd0;
   localparam logic [1:0]  LEN_H        = 2'd1;
   localparam logic [1:0]  LEN_L        = 2'd2;
   localparam logic [1:0]  LEN_BIG_L    = 2'd3;

   typedef enum logic [2:0] {
      PH_INTRO = 3'd0,
      PH_FLAGS = 3'd1,
      PH_WIDTH = 3'd2,
      PH_DOT   = 3'd3,
      PH_PREC  = 3'd4,
      PH_LEN   = 3'd5,
      PH_CONV  = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] width_acc;
      logic [31:0] precision_acc;
      logic [1:0]  justify;
      logic [1:0]  sign;
      logic        alt;
      logic [1:0]  length;
      logic [7:0]  span_count;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:         PH_INTRO,
      width_acc:     32'd0,
      precision_acc: PREC_UNSET,
      justify:       JUST_RIGHT,
      sign:          SIGN_NONE,
      alt:           1'b0,
      length:        LEN_NONE,
      span_count:    8'd0
   };

   typedef struct packed {
      logic signed [31:0] field_width;
      logic signed [31:0] field_precision;
      logic [1:0]         justify_mode;
      logic [1:0]         sign_mode;
      logic               alternate_form;
      logic [1:0]         length_kind;
      logic [7:0]         conversion_char;
      logic               conversion_found;
      logic               final_consumed;
      logic [7:0]         span_length;
   } result_type;

   function automatic logic is_conv_any(input logic [7:0] c);
      return c inside {"d", "i", "u", "o", "x", "X", "f", "e", "E", "g", "G",
                       "c", "s", "p", "n", "%"};
   endfunction

   function automatic logic is_conv_int(input logic [7:0] c);
      return c inside {"d", "i", "u", "o", "x", "X"};
   endfunction

   function automatic logic is_conv_uns(input logic [7:0] c);
      return c inside {"u", "o", "x", "X"};
   endfunction

endpackage

`default_nettype wire

[hdl/psp_step.sv]
// one parser step: decodes a byte against the current state, gives next state and result
`timescale 1ns / 1ps
`default_nettype none

module psp_step (
   input  psp_pkg::state_type  state_cur,
   input  logic [7:0]          char_in,
   input  logic [31:0]         star_value,
   output psp_pkg::state_type  state_nxt,
   output psp_pkg::result_type result,
   output logic                emit
);

   logic                is_digit;
   logic                is_star;
   logic                is_dot;
   logic                is_len;
   logic                is_flag;
   logic [3:0]          digit;
   psp_pkg::phase_type  eff_phase;
   logic [35:0]         acc_src;
   logic [35:0]         acc_prod;
   logic [31:0]         acc_digit;
   logic [7:0]          span_inc;
   logic                found;
   logic [7:0]          conv;

   assign is_digit = (char_in >= psp_pkg::CH_ZERO) && (char_in <= psp_pkg::CH_NINE);
   assign is_star  = (char_in == psp_pkg::CH_STAR);
   assign is_dot   = (char_in == psp_pkg::CH_DOT);
   assign is_len   = (char_in == psp_pkg::CH_LEN_H) || (char_in == psp_pkg::CH_LEN_L)
                     || (char_in == psp_pkg::CH_LEN_BIG_L);
   assign is_flag  = char_in inside {psp_pkg::CH_MINUS, psp_pkg::CH_PLUS, psp_pkg::CH_SPACE,
                                     psp_pkg::CH_HASH, psp_pkg::CH_ZERO};
   assign digit    = 4'(char_in - psp_pkg::CH_ZERO);

   // phase that actually handles the byte after falling through the optional parts
   always_comb begin
      case (state_cur.phase)
         psp_pkg::PH_FLAGS: begin
            if (is_flag)                   eff_phase = psp_pkg::PH_FLAGS;
            else if (is_digit || is_star)  eff_phase = psp_pkg::PH_WIDTH;
            else if (is_dot)               eff_phase = psp_pkg::PH_DOT;
            else if (is_len)               eff_phase = psp_pkg::PH_LEN;
            else                           eff_phase = psp_pkg::PH_CONV;
         end
         psp_pkg::PH_WIDTH: begin
            if (is_digit || is_star)       eff_phase = psp_pkg::PH_WIDTH;
            else if (is_dot)               eff_phase = psp_pkg::PH_DOT;
            else if (is_len)               eff_phase = psp_pkg::PH_LEN;
            else                           eff_phase = psp_pkg::PH_CONV;
         end
         psp_pkg::PH_DOT: begin
            if (is_dot)                    eff_phase = psp_pkg::PH_DOT;
            else if (is_len)               eff_phase = psp_pkg::PH_LEN;
            else                           eff_phase = psp_pkg::PH_CONV;
         end
         psp_pkg::PH_PREC: begin
            if (is_digit || is_star)       eff_phase = psp_pkg::PH_PREC;
            else if (is_len)               eff_phase = psp_pkg::PH_LEN;
            else                           eff_phase = psp_pkg::PH_CONV;
         end
         psp_pkg::PH_LEN: begin
            if (is_len)                    eff_phase = psp_pkg::PH_LEN;
            else                           eff_phase = psp_pkg::PH_CONV;
         end
         psp_pkg::PH_CONV:                 eff_phase = psp_pkg::PH_CONV;
         default:                          eff_phase = psp_pkg::PH_INTRO;
      endcase
   end

   // decimal accumulate with saturation: acc * 10 + digit
   assign acc_src   = (eff_phase == psp_pkg::PH_PREC) ? {4'd0, state_cur.precision_acc}
                                                      : {4'd0, state_cur.width_acc};
   assign acc_prod  = (acc_src << 3) + (acc_src << 1) + {32'd0, digit};
   assign acc_digit = (acc_prod > {4'd0, psp_pkg::SAT_MAX}) ? psp_pkg::SAT_MAX
                                                            : acc_prod[31:0];

   assign span_inc = (state_cur.span_count == psp_pkg::SPAN_MAX) ? state_cur.span_count
                                                                 : state_cur.span_count + 8'd1;

   assign found = (char_in == psp_pkg::CH_NUL) || psp_pkg::is_conv_any(char_in);
   assign conv  = found ? char_in : psp_pkg::CH_NUL;

   // next phase
   always_comb begin
      state_nxt.phase = state_cur.phase;
      case (eff_phase)
         psp_pkg::PH_FLAGS: state_nxt.phase = psp_pkg::PH_FLAGS;
         psp_pkg::PH_WIDTH: state_nxt.phase = is_star ? psp_pkg::PH_DOT : psp_pkg::PH_WIDTH;
         psp_pkg::PH_DOT:   state_nxt.phase = psp_pkg::PH_PREC;
         psp_pkg::PH_PREC:  state_nxt.phase = is_star ? psp_pkg::PH_LEN : psp_pkg::PH_PREC;
         psp_pkg::PH_LEN:   state_nxt.phase = psp_pkg::PH_CONV;
         psp_pkg::PH_CONV:  state_nxt.phase = psp_pkg::PH_INTRO;
         default:           state_nxt.phase = psp_pkg::PH_FLAGS;
      endcase
   end

   // datapath state and result
   always_comb begin
      state_nxt.width_acc     = state_cur.width_acc;
      state_nxt.precision_acc = state_cur.precision_acc;
      state_nxt.justify       = state_cur.justify;
      state_nxt.sign          = state_cur.sign;
      state_nxt.alt           = state_cur.alt;
      state_nxt.length        = state_cur.length;
      state_nxt.span_count    = span_inc;
      emit                    = 1'b0;

      result.field_width      = state_cur.width_acc;
      result.field_precision  = state_cur.precision_acc;
      result.justify_mode     = state_cur.justify;
      result.sign_mode        = state_cur.sign;
      result.alternate_form   = state_cur.alt;
      result.length_kind      = state_cur.length;
      result.conversion_char  = conv;
      result.conversion_found = found;
      result.final_consumed   = found;
      result.span_length      = found ? span_inc : state_cur.span_count;

      if ((conv != psp_pkg::CH_NUL) && psp_pkg::is_conv_int(conv)
          && (state_cur.justify == psp_pkg::JUST_ZERO)
          && (state_cur.precision_acc != psp_pkg::PREC_UNSET)) begin
         result.justify_mode = psp_pkg::JUST_RIGHT;
      end
      if ((conv != psp_pkg::CH_NUL) && psp_pkg::is_conv_uns(conv)) begin
         result.sign_mode = psp_pkg::SIGN_NONE;
      end

      case (eff_phase)
         psp_pkg::PH_FLAGS: begin
            case (char_in)
               psp_pkg::CH_MINUS: state_nxt.justify = psp_pkg::JUST_LEFT;
               psp_pkg::CH_PLUS:  state_nxt.sign    = psp_pkg::SIGN_PLUS;
               psp_pkg::CH_SPACE: begin
                  if (state_cur.sign == psp_pkg::SIGN_NONE) state_nxt.sign = psp_pkg::SIGN_SPACE;
               end
               psp_pkg::CH_HASH:  state_nxt.alt     = 1'b1;
               default: begin
                  if (state_cur.justify == psp_pkg::JUST_RIGHT) begin
                     state_nxt.justify = psp_pkg::JUST_ZERO;
                  end
               end
            endcase
         end
         psp_pkg::PH_WIDTH: state_nxt.width_acc = is_star ? star_value : acc_digit;
         psp_pkg::PH_DOT:   state_nxt.precision_acc = 32'd0;
         psp_pkg::PH_PREC:  state_nxt.precision_acc = is_star ? star_value : acc_digit;
         psp_pkg::PH_LEN: begin
            case (char_in)
               psp_pkg::CH_LEN_H: state_nxt.length = psp_pkg::LEN_H;
               psp_pkg::CH_LEN_L: state_nxt.length = psp_pkg::LEN_L;
               default:           state_nxt.length = psp_pkg::LEN_BIG_L;
            endcase
         end
         psp_pkg::PH_CONV: begin
            state_nxt.width_acc     = psp_pkg::STATE_RESET.width_acc;
            state_nxt.precision_acc = psp_pkg::STATE_RESET.precision_acc;
            state_nxt.justify       = psp_pkg::STATE_RESET.justify;
            state_nxt.sign          = psp_pkg::STATE_RESET.sign;
            state_nxt.alt           = psp_pkg::STATE_RESET.alt;
            state_nxt.length        = psp_pkg::STATE_RESET.length;
            state_nxt.span_count    = psp_pkg::STATE_RESET.span_count;
            emit                    = 1'b1;
         end
         default:           state_nxt.span_count = 8'd1;
      endcase
   end

endmodule

`default_nettype wire

[hdl/printf_spec_parser.sv]
// top level of the format specifier parser: state and result registers, handshakes
//
//  channel  dir  handshake             word
//  req      in   req_valid/req_ready   format byte and star argument
//  rsp      out  rsp_valid/rsp_ready   packed specifier
//
// every byte takes one cycle through the step logic into the state register
// a byte may be taken in every cycle while the result register is empty or being read
// the specifier appears on rsp the cycle after its conversion byte is taken
// a result word held by a low rsp_ready stalls req, whatever the byte
// synchronous active high reset returns the parser to the introducer state
`timescale 1ns / 1ps
`default_nettype none

module printf_spec_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_in,
   input  logic signed [31:0] req_star_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_field_width,
   output logic signed [31:0] rsp_field_precision,
   output logic [1:0]         rsp_justify_mode,
   output logic [1:0]         rsp_sign_mode,
   output logic               rsp_alternate_form,
   output logic [1:0]         rsp_length_kind,
   output logic [7:0]         rsp_conversion_char,
   output logic               rsp_conversion_found,
   output logic               rsp_final_consumed,
   output logic [7:0]         rsp_span_length
);

   psp_pkg::state_type  state_ff;
   psp_pkg::state_type  state_in;
   psp_pkg::result_type result_ff;
   psp_pkg::result_type result_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                emit;
   logic                req_fire;

   psp_step u_step (
      .state_cur  (state_ff),
      .char_in    (req_char_in),
      .star_value (req_star_value),
      .state_nxt  (state_in),
      .result     (result_in),
      .emit       (emit)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psp_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_field_width      = result_ff.field_width;
   assign rsp_field_precision  = result_ff.field_precision;
   assign rsp_justify_mode     = result_ff.justify_mode;
   assign rsp_sign_mode        = result_ff.sign_mode;
   assign rsp_alternate_form   = result_ff.alternate_form;
   assign rsp_length_kind      = result_ff.length_kind;
   assign rsp_conversion_char  = result_ff.conversion_char;
   assign rsp_conversion_found = result_ff.conversion_found;
   assign rsp_final_consumed   = result_ff.final_consumed;
   assign rsp_span_length      = result_ff.span_length;

   a_emit_resets: assert property (@(posedge clock) disable iff (reset)
      req_fire && emit |=> rsp_valid_ff && (state_ff.phase == psp_pkg::PH_INTRO))
      else $error("specifier emitted without returning to introducer state");

   a_emit_only_in_conv: assert property (@(posedge clock) disable iff (reset)
      emit |-> (state_ff.phase == psp_pkg::PH_FLAGS || state_ff.phase == psp_pkg::PH_WIDTH
                || state_ff.phase == psp_pkg::PH_DOT || state_ff.phase == psp_pkg::PH_PREC
                || state_ff.phase == psp_pkg::PH_LEN || state_ff.phase == psp_pkg::PH_CONV))
      else $error("emit raised from introducer state");

   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.span_length != 8'd0))
      else $error("result word with empty span");

   a_intro_span: assert property (@(posedge clock) disable iff (reset)
      req_fire && (state_ff.phase == psp_pkg::PH_INTRO)
      |=> (state_ff.span_count == 8'd1) && (state_ff.phase == psp_pkg::PH_FLAGS))
      else $error("introducer not counted");

endmodule

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for printf_spec_parser: directed table, random specifiers, predictor
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_WORDS = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [7:0]          c;
      logic [31:0]         star;
      bit                  typed;
      psp_pkg::result_type res;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_char_in = 8'd0;
   logic signed [31:0] req_star_value = 32'sd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_field_width;
   logic signed [31:0] rsp_field_precision;
   logic [1:0]         rsp_justify_mode;
   logic [1:0]         rsp_sign_mode;
   logic               rsp_alternate_form;
   logic [1:0]         rsp_length_kind;
   logic [7:0]         rsp_conversion_char;
   logic               rsp_conversion_found;
   logic               rsp_final_consumed;
   logic [7:0]         rsp_span_length;

   bit                  req_typed = 1'b0;
   psp_pkg::result_type req_typed_spec = '0;
   bit                  calm = 1'b0;
   bit                  rsp_hold = 1'b0;
   int                  words_sent = 0;
   int                  mismatches = 0;
   int                  idle_cycles = 0;
   psp_pkg::state_type  spec_st = psp_pkg::STATE_RESET;
   psp_pkg::result_type pending_specs[$];
   row_type             directed[$];

   printf_spec_parser dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_char_in          (req_char_in),
      .req_star_value       (req_star_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_field_width      (rsp_field_width),
      .rsp_field_precision  (rsp_field_precision),
      .rsp_justify_mode     (rsp_justify_mode),
      .rsp_sign_mode        (rsp_sign_mode),
      .rsp_alternate_form   (rsp_alternate_form),
      .rsp_length_kind      (rsp_length_kind),
      .rsp_conversion_char  (rsp_conversion_char),
      .rsp_conversion_found (rsp_conversion_found),
      .rsp_final_consumed   (rsp_final_consumed),
      .rsp_span_length      (rsp_span_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      return ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
   endfunction

   function automatic bit in_class(string set, logic [7:0] c);
      int i;
      for (i = 0; i < set.len(); i++) begin
         if (set[i] == c) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [31:0] add_digit(logic [31:0] acc, logic [31:0] d);
      if (acc > (psp_pkg::SAT_MAX - d) / 32'd10) begin
         return psp_pkg::SAT_MAX;
      end
      return acc * 32'd10 + d;
   endfunction

   function automatic void bump_span();
      if (spec_st.span_count < psp_pkg::SPAN_MAX) begin
         spec_st.span_count = spec_st.span_count + 8'd1;
      end
   endfunction

   function automatic bit parse_byte(input logic [7:0] c, input logic [31:0] star,
                                     output psp_pkg::result_type r);
      bit         digit;
      bit         found;
      logic [7:0] conv;
      logic [1:0] just;
      logic [1:0] sgn;
      r = '0;
      digit = (c >= psp_pkg::CH_ZERO) && (c <= psp_pkg::CH_NINE);
      if (spec_st.phase == psp_pkg::PH_INTRO) begin
         spec_st.span_count = 8'd1;
         spec_st.phase = psp_pkg::PH_FLAGS;
         return 1'b0;
      end
      if (spec_st.phase == psp_pkg::PH_FLAGS) begin
         if (c == psp_pkg::CH_MINUS || c == psp_pkg::CH_PLUS || c == psp_pkg::CH_SPACE
             || c == psp_pkg::CH_HASH || c == psp_pkg::CH_ZERO) begin
            case (c)
               psp_pkg::CH_MINUS: spec_st.justify = psp_pkg::JUST_LEFT;
               psp_pkg::CH_PLUS:  spec_st.sign = psp_pkg::SIGN_PLUS;
               psp_pkg::CH_SPACE: begin
                  if (spec_st.sign < psp_pkg::SIGN_SPACE) spec_st.sign = psp_pkg::SIGN_SPACE;
               end
               psp_pkg::CH_HASH:  spec_st.alt = 1'b1;
               default: begin
                  if (spec_st.justify < psp_pkg::JUST_ZERO) spec_st.justify = psp_pkg::JUST_ZERO;
               end
            endcase
            bump_span();
            return 1'b0;
         end
         spec_st.phase = psp_pkg::PH_WIDTH;
      end
      if (spec_st.phase == psp_pkg::PH_WIDTH) begin
         if (digit) begin
            spec_st.width_acc = add_digit(spec_st.width_acc, {24'd0, c - psp_pkg::CH_ZERO});
            bump_span();
            return 1'b0;
         end
         spec_st.phase = psp_pkg::PH_DOT;
         if (c == psp_pkg::CH_STAR) begin
            spec_st.width_acc = star;
            bump_span();
            return 1'b0;
         end
      end
      if (spec_st.phase == psp_pkg::PH_DOT) begin
         if (c == psp_pkg::CH_DOT) begin
            spec_st.precision_acc = 32'd0;
            spec_st.phase = psp_pkg::PH_PREC;
            bump_span();
            return 1'b0;
         end
         spec_st.phase = psp_pkg::PH_LEN;
      end
      if (spec_st.phase == psp_pkg::PH_PREC) begin
         if (digit) begin
            spec_st.precision_acc = add_digit(spec_st.precision_acc,
                                              {24'd0, c - psp_pkg::CH_ZERO});
            bump_span();
            return 1'b0;
         end
         spec_st.phase = psp_pkg::PH_LEN;
         if (c == psp_pkg::CH_STAR) begin
            spec_st.precision_acc = star;
            bump_span();
            return 1'b0;
         end
      end
      if (spec_st.phase == psp_pkg::PH_LEN) begin
         spec_st.phase = psp_pkg::PH_CONV;
         if (c == psp_pkg::CH_LEN_H || c == psp_pkg::CH_LEN_L || c == psp_pkg::CH_LEN_BIG_L) begin
            spec_st.length = (c == psp_pkg::CH_LEN_H) ? psp_pkg::LEN_H
                           : (c == psp_pkg::CH_LEN_L) ? psp_pkg::LEN_L : psp_pkg::LEN_BIG_L;
            bump_span();
            return 1'b0;
         end
      end
      found = (c == psp_pkg::CH_NUL) || in_class("diuoxXfeEgGcspn%", c);
      conv = found ? c : psp_pkg::CH_NUL;
      if (found) begin
         bump_span();
      end
      just = spec_st.justify;
      sgn = spec_st.sign;
      if (conv != psp_pkg::CH_NUL && in_class("diuoxX", conv) && just == psp_pkg::JUST_ZERO
          && spec_st.precision_acc != psp_pkg::PREC_UNSET) begin
         just = psp_pkg::JUST_RIGHT;
      end
      if (conv != psp_pkg::CH_NUL && in_class("uoxX", conv)) begin
         sgn = psp_pkg::SIGN_NONE;
      end
      r.field_width = spec_st.width_acc;
      r.field_precision = spec_st.precision_acc;
      r.justify_mode = just;
      r.sign_mode = sgn;
      r.alternate_form = spec_st.alt;
      r.length_kind = spec_st.length;
      r.conversion_char = conv;
      r.conversion_found = found;
      r.final_consumed = found;
      r.span_length = spec_st.span_count;
      spec_st = psp_pkg::STATE_RESET;
      return 1'b1;
   endfunction

   function automatic psp_pkg::result_type spec(logic [31:0] w, logic [31:0] p, logic [1:0] j,
                                                logic [1:0] s, logic a, logic [1:0] l,
                                                logic [7:0] ch, logic f, logic [7:0] span);
      psp_pkg::result_type r;
      r = '{w, p, j, s, a, l, ch, f, f, span};
      return r;
   endfunction

   task automatic cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      psp_pkg::result_type got;
      psp_pkg::result_type want;
      psp_pkg::result_type pred;
      bit                  emitted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_field_width, rsp_field_precision, rsp_justify_mode, rsp_sign_mode,
                    rsp_alternate_form, rsp_length_kind, rsp_conversion_char,
                    rsp_conversion_found, rsp_final_consumed, rsp_span_length};
            if (pending_specs.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected specifier %h", $time, got);
            end else begin
               want = pending_specs.pop_front();
               cmp("field_width", want.field_width, got.field_width);
               cmp("field_precision", want.field_precision, got.field_precision);
               cmp("justify_mode", 32'(want.justify_mode), 32'(got.justify_mode));
               cmp("sign_mode", 32'(want.sign_mode), 32'(got.sign_mode));
               cmp("alternate_form", 32'(want.alternate_form), 32'(got.alternate_form));
               cmp("length_kind", 32'(want.length_kind), 32'(got.length_kind));
               cmp("conversion_char", 32'(want.conversion_char), 32'(got.conversion_char));
               cmp("conversion_found", 32'(want.conversion_found),
                   32'(got.conversion_found));
               cmp("final_consumed", 32'(want.final_consumed), 32'(got.final_consumed));
               cmp("span_length", 32'(want.span_length), 32'(got.span_length));
            end
         end
         if (req_valid && req_ready) begin
            emitted = parse_byte(req_char_in, req_star_value, pred);
            if (emitted) begin
               pending_specs.push_back(req_typed ? req_typed_spec : pred);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("FAIL printf_spec_parser");
               $finish;
            end
         end
      end
   end

   initial begin : rsp_side
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [7:0] c, input logic [31:0] star, input bit typed,
                            input psp_pkg::result_type res);
      req_valid <= 1'b1;
      req_char_in <= c;
      req_star_value <= star;
      req_typed <= typed;
      req_typed_spec <= res;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (!calm && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   task automatic put(input logic [7:0] c);
      send_word(c, $urandom, 1'b0, '0);
   endtask

   task automatic put_digits(input int n);
      repeat (n) put(psp_pkg::CH_ZERO + 8'($urandom_range(9)));
   endtask

   task automatic random_spec();
      string flags;
      string convs;
      int    n;
      flags = "-+ #0";
      convs = "diuoxXfeEgGcspn%";
      put(8'($urandom));
      n = ($urandom_range(199) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 4);
      repeat (n) put(flags[$urandom_range(4)]);
      case ($urandom_range(4))
         1, 2: begin
            put_digits(($urandom_range(7) == 0) ? $urandom_range(10, 12)
                                                : $urandom_range(1, 3));
         end
         3: begin
            put_digits($urandom_range(1, 3));
            put(psp_pkg::CH_STAR);
         end
         4: put(psp_pkg::CH_STAR);
         default: ;
      endcase
      if ($urandom_range(1) == 0) begin
         put(psp_pkg::CH_DOT);
         case ($urandom_range(3))
            1: begin
               put_digits(($urandom_range(7) == 0) ? $urandom_range(10, 12)
                                                   : $urandom_range(1, 3));
            end
            2: put(psp_pkg::CH_STAR);
            default: ;
         endcase
      end
      if ($urandom_range(1) == 0) begin
         case ($urandom_range(2))
            0: put(psp_pkg::CH_LEN_H);
            1: put(psp_pkg::CH_LEN_L);
            default: put(psp_pkg::CH_LEN_BIG_L);
         endcase
      end
      n = $urandom_range(99);
      if (n < 80) begin
         put(convs[$urandom_range(convs.len() - 1)]);
      end else if (n < 85) begin
         put(psp_pkg::CH_NUL);
      end else begin
         put(8'($urandom));
      end
   endtask

   task automatic wait_all_specs();
      @(posedge clock);
      while (pending_specs.size() != 0) @(posedge clock);
   endtask

   task automatic row(input logic [7:0] c, input logic [31:0] star, input bit typed,
                      input psp_pkg::result_type res);
      row_type r;
      r = '{c, star, typed, res};
      directed.push_back(r);
   endtask

   initial begin : stimulus
      int  i;
      int  stop_at;
      bit  paused;
      // plain conversion right after reset
      row("%", $urandom, 1'b0, '0);
      row("d", $urandom, 1'b1, spec(32'd0, psp_pkg::PREC_UNSET, psp_pkg::JUST_RIGHT,
                                    psp_pkg::SIGN_NONE, 1'b0, psp_pkg::LEN_NONE, "d", 1'b1,
                                    8'd2));
      // every flag with both priorities, star width and precision at the extremes
      row("%", $urandom, 1'b0, '0);
      row(psp_pkg::CH_MINUS, $urandom, 1'b0, '0);
      row(psp_pkg::CH_ZERO, $urandom, 1'b0, '0);
      row(psp_pkg::CH_PLUS, $urandom, 1'b0, '0);
      row(psp_pkg::CH_SPACE, $urandom, 1'b0, '0);
      row(psp_pkg::CH_HASH, $urandom, 1'b0, '0);
      row(psp_pkg::CH_STAR, 32'h8000_0000, 1'b0, '0);
      row(psp_pkg::CH_DOT, $urandom, 1'b0, '0);
      row(psp_pkg::CH_STAR, 32'h7FFF_FFFF, 1'b0, '0);
      row(psp_pkg::CH_LEN_BIG_L, $urandom, 1'b0, '0);
      row("f", $urandom, 1'b1, spec(32'h8000_0000, 32'h7FFF_FFFF, psp_pkg::JUST_LEFT,
                                    psp_pkg::SIGN_PLUS, 1'b1, psp_pkg::LEN_BIG_L, "f", 1'b1,
                                    8'd11));
      // unknown conversion is not consumed
      row(8'hFF, $urandom, 1'b0, '0);
      row("q", $urandom, 1'b1, spec(32'd0, psp_pkg::PREC_UNSET, psp_pkg::JUST_RIGHT,
                                    psp_pkg::SIGN_NONE, 1'b0, psp_pkg::LEN_NONE,
                                    psp_pkg::CH_NUL, 1'b0, 8'd1));
      // nul terminates as a found conversion
      row(8'h00, $urandom, 1'b0, '0);
      row(psp_pkg::CH_NUL, $urandom, 1'b1, spec(32'd0, psp_pkg::PREC_UNSET,
                                                psp_pkg::JUST_RIGHT, psp_pkg::SIGN_NONE, 1'b0,
                                                psp_pkg::LEN_NONE, psp_pkg::CH_NUL, 1'b1,
                                                8'd2));
      // zero padding dropped with precision on an integer conversion
      row("%", $urandom, 1'b0, '0);
      row(psp_pkg::CH_ZERO, $urandom, 1'b0, '0);
      row("5", $urandom, 1'b0, '0);
      row(psp_pkg::CH_DOT, $urandom, 1'b0, '0);
      row("3", $urandom, 1'b0, '0);
      row("x", $urandom, 1'b0, '0);
      // empty precision, l modifier, sign cleared on unsigned
      row("%", $urandom, 1'b0, '0);
      row(psp_pkg::CH_PLUS, $urandom, 1'b0, '0);
      row(psp_pkg::CH_DOT, $urandom, 1'b0, '0);
      row(psp_pkg::CH_LEN_L, $urandom, 1'b0, '0);
      row("u", $urandom, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < directed.size(); i++) begin
         send_word(directed[i].c, directed[i].star, directed[i].typed, directed[i].res);
      end

      rsp_hold = 1'b1;
      paused = 1'b0;
      stop_at = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         if ($urandom_range(39) == 0) begin
            calm = ~calm;
         end
         if (!paused && words_sent >= stop_at - RANDOM_WORDS / 2) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            wait_all_specs();
         end
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 5)) put(8'($urandom));
         end else begin
            random_spec();
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      wait_all_specs();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS printf_spec_parser");
      end else begin
         $display("FAIL printf_spec_parser");
      end
      $finish;
   end

endmodule
